FILE: hw/rtl/fjik_pkg.sv
// finger joint ik solver: shared types, command codes and constants
// used by the config block, controller, datapath and top level
package fjik_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [31:0] ANG_PI = 32'sd843314857;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;

    localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755423, 32'sd8385879, 32'sd4193963, 32'sd2097109,
        32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
        32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192
    };

    // terms of the quaternion product that enter negated, index {component, term}
    localparam logic [15:0] TERM_NEG = 16'h428E;

    localparam logic [3:0] ROT_LAST = 4'(CORDIC_STEPS - 1);
    localparam logic [3:0] MAC_LAST = 4'd15;
    localparam logic [3:0] NORM_LAST = 4'd3;
    localparam logic [3:0] GRAD_LAST = 4'd6;

    typedef enum logic [2:0] {
        REG_STEP_GAIN   = 3'd0,
        REG_ITER_LIMIT  = 3'd1,
        REG_STOP_THRESH = 3'd2,
        REG_COUP_RATIO  = 3'd3,
        REG_COUP_WEIGHT = 3'd4,
        REG_PIP_LIMIT   = 3'd5,
        REG_DIP_LIMIT   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [14:0] step_gain;
        logic [3:0]  iteration_limit;
        logic [14:0] stop_threshold;
        logic [14:0] coupling_ratio;
        logic [14:0] coupling_weight;
        logic [14:0] pip_upper_limit;
        logic [14:0] dip_upper_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        quat_t              base;
        logic signed [15:0] mcp_angle;
        quat_t              tip;
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT_INIT,
        S_ROT_STEP,
        S_ROT_DONE,
        S_MUL,
        S_ERR_FIX,
        S_NORM,
        S_TEST,
        S_GRAD,
        S_CHECK,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_ROT_DONE,
        OP_MAC,
        OP_ERR_FIX,
        OP_NORM,
        OP_GRAD,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        MS_BASE_ROT,
        MS_REL,
        MS_ERR
    } mul_sel_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] idx;
        mul_sel_t   msel;
        logic       fk;
    } dp_cmd_t;

    typedef struct packed {
        logic stop;
    } dp_status_t;

endpackage

FILE: hw/rtl/fjik_req_if.sv
// request channel: valid/ready handshake with the input item payload
// depends on nothing
interface fjik_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] base_w;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic signed [15:0] mcp_angle;
    logic signed [15:0] tip_w;
    logic signed [15:0] tip_x;
    logic signed [15:0] tip_y;
    logic signed [15:0] tip_z;

    modport source (
        output valid, base_w, base_x, base_y, base_z, mcp_angle,
               tip_w, tip_x, tip_y, tip_z,
        input  ready
    );
    modport sink (
        input  valid, base_w, base_x, base_y, base_z, mcp_angle,
               tip_w, tip_x, tip_y, tip_z,
        output ready
    );
endinterface

FILE: hw/rtl/fjik_rsp_if.sv
// result channel: valid/ready handshake with the refined joint angles
// depends on nothing
interface fjik_rsp_if;
    logic        valid;
    logic        ready;
    logic [14:0] pip_angle;
    logic [14:0] dip_angle;

    modport source (output valid, pip_angle, dip_angle, input ready);
    modport sink (input valid, pip_angle, dip_angle, output ready);
endinterface

FILE: hw/rtl/fjik_cfg.sv
// apb configuration registers of the finger joint ik solver
// depends on fjik_pkg
module fjik_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fjik_pkg::cfg_t      cfg
);

    fjik_pkg::cfg_t cfg_reg;
    fjik_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (fjik_pkg::reg_idx_t'(paddr[4:2]))
                fjik_pkg::REG_STEP_GAIN:   cfg_next.step_gain       = pwdata[14:0];
                fjik_pkg::REG_ITER_LIMIT:  cfg_next.iteration_limit = pwdata[3:0];
                fjik_pkg::REG_STOP_THRESH: cfg_next.stop_threshold  = pwdata[14:0];
                fjik_pkg::REG_COUP_RATIO:  cfg_next.coupling_ratio  = pwdata[14:0];
                fjik_pkg::REG_COUP_WEIGHT: cfg_next.coupling_weight = pwdata[14:0];
                fjik_pkg::REG_PIP_LIMIT:   cfg_next.pip_upper_limit = pwdata[14:0];
                fjik_pkg::REG_DIP_LIMIT:   cfg_next.dip_upper_limit = pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (fjik_pkg::reg_idx_t'(paddr[4:2]))
            fjik_pkg::REG_STEP_GAIN:   prdata = {17'b0, cfg_reg.step_gain};
            fjik_pkg::REG_ITER_LIMIT:  prdata = {28'b0, cfg_reg.iteration_limit};
            fjik_pkg::REG_STOP_THRESH: prdata = {17'b0, cfg_reg.stop_threshold};
            fjik_pkg::REG_COUP_RATIO:  prdata = {17'b0, cfg_reg.coupling_ratio};
            fjik_pkg::REG_COUP_WEIGHT: prdata = {17'b0, cfg_reg.coupling_weight};
            fjik_pkg::REG_PIP_LIMIT:   prdata = {17'b0, cfg_reg.pip_upper_limit};
            fjik_pkg::REG_DIP_LIMIT:   prdata = {17'b0, cfg_reg.dip_upper_limit};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_gain       <= 15'd8192;
            cfg_reg.iteration_limit <= 4'd5;
            cfg_reg.stop_threshold  <= 15'd2;
            cfg_reg.coupling_ratio  <= 15'd10977;
            cfg_reg.coupling_weight <= 15'd4915;
            cfg_reg.pip_upper_limit <= 15'd14295;
            cfg_reg.dip_upper_limit <= 15'd10011;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/fjik_ctrl.sv
// controller state machine: sequences rotation, products, norm test and
// gradient steps of the datapath; depends on fjik_pkg
module fjik_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  logic [3:0]             iter_limit,
    input  fjik_pkg::dp_status_t   status,
    output fjik_pkg::dp_cmd_t      cmd
);

    fjik_pkg::ctrl_state_t state_reg, state_next;
    fjik_pkg::mul_sel_t    msel_reg, msel_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [3:0]            iter_reg, iter_next;
    logic                  phase_reg, phase_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        msel_next  = msel_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            fjik_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fjik_pkg::S_ROT_INIT;
                    phase_next = 1'b0;
                    iter_next  = '0;
                end
            end
            fjik_pkg::S_ROT_INIT:
            begin
                state_next = fjik_pkg::S_ROT_STEP;
                cnt_next   = '0;
            end
            fjik_pkg::S_ROT_STEP:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == fjik_pkg::ROT_LAST)
                begin
                    state_next = fjik_pkg::S_ROT_DONE;
                end
            end
            fjik_pkg::S_ROT_DONE:
            begin
                state_next = fjik_pkg::S_MUL;
                cnt_next   = '0;
                msel_next  = phase_reg ? fjik_pkg::MS_ERR : fjik_pkg::MS_BASE_ROT;
            end
            fjik_pkg::S_MUL:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == fjik_pkg::MAC_LAST)
                begin
                    unique case (msel_reg)
                        fjik_pkg::MS_BASE_ROT: msel_next  = fjik_pkg::MS_REL;
                        fjik_pkg::MS_REL:      state_next = fjik_pkg::S_CHECK;
                        default:               state_next = fjik_pkg::S_ERR_FIX;
                    endcase
                end
            end
            fjik_pkg::S_ERR_FIX:
            begin
                state_next = fjik_pkg::S_NORM;
                cnt_next   = '0;
            end
            fjik_pkg::S_NORM:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == fjik_pkg::NORM_LAST)
                begin
                    state_next = fjik_pkg::S_TEST;
                end
            end
            fjik_pkg::S_TEST:
            begin
                cnt_next   = '0;
                state_next = status.stop ? fjik_pkg::S_OUT : fjik_pkg::S_GRAD;
            end
            fjik_pkg::S_GRAD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == fjik_pkg::GRAD_LAST)
                begin
                    iter_next  = iter_reg + 4'd1;
                    state_next = fjik_pkg::S_CHECK;
                end
            end
            fjik_pkg::S_CHECK:
            begin
                if (iter_reg == iter_limit)
                begin
                    state_next = fjik_pkg::S_OUT;
                end
                else
                begin
                    state_next = fjik_pkg::S_ROT_INIT;
                    phase_next = 1'b1;
                end
            end
            fjik_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = fjik_pkg::S_IDLE;
                end
            end
            default: state_next = fjik_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = fjik_pkg::OP_NONE;
        cmd.idx  = cnt_reg;
        cmd.msel = msel_reg;
        cmd.fk   = phase_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            fjik_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = fjik_pkg::OP_LOAD;
                end
            end
            fjik_pkg::S_ROT_INIT: cmd.op = fjik_pkg::OP_ROT_INIT;
            fjik_pkg::S_ROT_STEP: cmd.op = fjik_pkg::OP_ROT_STEP;
            fjik_pkg::S_ROT_DONE: cmd.op = fjik_pkg::OP_ROT_DONE;
            fjik_pkg::S_MUL:      cmd.op = fjik_pkg::OP_MAC;
            fjik_pkg::S_ERR_FIX:  cmd.op = fjik_pkg::OP_ERR_FIX;
            fjik_pkg::S_NORM:     cmd.op = fjik_pkg::OP_NORM;
            fjik_pkg::S_GRAD:     cmd.op = fjik_pkg::OP_GRAD;
            fjik_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = fjik_pkg::OP_OUT;
                end
            end
            default: cmd.op = fjik_pkg::OP_NONE;
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || (cmd.op == fjik_pkg::OP_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fjik_pkg::S_IDLE;
            msel_reg      <= fjik_pkg::MS_BASE_ROT;
            cnt_reg       <= '0;
            iter_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msel_reg      <= msel_next;
            cnt_reg       <= cnt_next;
            iter_reg      <= iter_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/fjik_dp.sv
// datapath: cordic rotation, shared multiplier with accumulator, error
// norm test, gradient update and angle estimates; depends on fjik_pkg
module fjik_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fjik_pkg::dp_cmd_t     cmd,
    input  fjik_pkg::cfg_t        cfg,
    input  fjik_pkg::req_t        req,
    output fjik_pkg::dp_status_t  status,
    output logic [14:0]           pip_angle,
    output logic [14:0]           dip_angle
);

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

    function automatic fjik_pkg::quat_t conj(input fjik_pkg::quat_t q);
        fjik_pkg::quat_t r;
        r.w = q.w;
        r.x = neg_sat(q.x);
        r.y = neg_sat(q.y);
        r.z = neg_sat(q.z);
        return r;
    endfunction

    function automatic logic signed [15:0] qget(input fjik_pkg::quat_t q,
                                                input logic [1:0] i);
        logic signed [15:0] v;
        case (i)
            2'd0:    v = q.w;
            2'd1:    v = q.x;
            2'd2:    v = q.y;
            default: v = q.z;
        endcase
        return v;
    endfunction

    function automatic fjik_pkg::quat_t qset(input fjik_pkg::quat_t q, input logic [1:0] i,
                                             input logic signed [15:0] v);
        fjik_pkg::quat_t r;
        r = q;
        case (i)
            2'd0:    r.w = v;
            2'd1:    r.x = v;
            2'd2:    r.y = v;
            default: r.z = v;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] qfix(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd8192) >>> 14;
        if (r > 64'sd32767)
            return 16'sh7fff;
        else if (r < -64'sd32768)
            return 16'sh8000;
        return r[15:0];
    endfunction

    function automatic logic [32:0] reduce_angle(input logic signed [31:0] z_in);
        logic signed [31:0] z;
        logic               neg;
        z   = z_in;
        neg = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            if (z > fjik_pkg::ANG_HALF_PI)
            begin
                z   = z - fjik_pkg::ANG_PI;
                neg = !neg;
            end
            else if (z < -fjik_pkg::ANG_HALF_PI)
            begin
                z   = z + fjik_pkg::ANG_PI;
                neg = !neg;
            end
        end
        return {neg, z};
    endfunction

    function automatic logic [14:0] clamp_angle(input logic signed [27:0] v,
                                                input logic [14:0] lim);
        if (v < 28'sd0)
            return 15'd0;
        else if (v > $signed({13'b0, lim}))
            return lim;
        return v[14:0];
    endfunction

    function automatic logic signed [15:0] rot_out(input logic signed [32:0] v,
                                                   input logic neg);
        logic signed [32:0] r;
        logic signed [15:0] s;
        r = (v + 33'sd32768) >>> 16;
        if (r > 33'sd16384)
            s = 16'sd16384;
        else if (r < -33'sd16384)
            s = -16'sd16384;
        else
            s = r[15:0];
        return neg ? -s : s;
    endfunction

    fjik_pkg::quat_t    base_reg, tip_reg, qres_reg, qrel_reg;
    logic signed [15:0] mcp_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               neg_reg;
    logic signed [15:0] rc_reg, rs_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] ce_reg;
    logic [29:0]        kl_reg;
    logic signed [35:0] gd_reg, gp_reg;
    logic [14:0]        pip_reg, dip_reg;
    logic               stop_reg;
    logic [14:0]        opip_reg, odip_reg;

    fjik_pkg::quat_t    rot_q, a_vec, b_vec;
    logic [1:0]         comp, term;
    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [53:0] prod;
    logic signed [63:0] acc_mac, nsum, gsum;
    logic signed [53:0] mac_term;
    logic [32:0]        red;
    logic signed [31:0] z_init;
    logic signed [32:0] dx, dy;
    logic signed [35:0] ey13;
    logic signed [53:0] r14, r28;
    logic signed [27:0] pip_sum, dip_sum;

    assign comp  = cmd.idx[3:2];
    assign term  = cmd.idx[1:0];
    assign rot_q = '{w: rc_reg, x: 16'sd0, y: rs_reg, z: 16'sd0};

    always_comb
    begin
        case (cmd.msel)
            fjik_pkg::MS_BASE_ROT:
            begin
                a_vec = base_reg;
                b_vec = rot_q;
            end
            fjik_pkg::MS_REL:
            begin
                a_vec = conj(qres_reg);
                b_vec = tip_reg;
            end
            default:
            begin
                a_vec = conj(rot_q);
                b_vec = qrel_reg;
            end
        endcase
    end

    // operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            fjik_pkg::OP_MAC:
            begin
                mul_a = 36'(qget(a_vec, term));
                mul_b = 18'(qget(b_vec, comp ^ term));
            end
            fjik_pkg::OP_NORM:
            begin
                if (term == 2'd3)
                begin
                    mul_a = $signed({21'b0, cfg.stop_threshold});
                    mul_b = $signed({3'b0, cfg.stop_threshold});
                end
                else
                begin
                    mul_a = 36'(qget(qres_reg, 2'(term + 2'd1)));
                    mul_b = 18'(qget(qres_reg, 2'(term + 2'd1)));
                end
            end
            fjik_pkg::OP_GRAD:
            begin
                case (cmd.idx)
                    4'd0:
                    begin
                        mul_a = $signed({21'b0, pip_reg});
                        mul_b = $signed({3'b0, cfg.coupling_ratio});
                    end
                    4'd1:
                    begin
                        mul_a = $signed({21'b0, cfg.coupling_ratio});
                        mul_b = $signed({3'b0, cfg.coupling_weight});
                    end
                    4'd2:
                    begin
                        mul_a = 36'(ce_reg);
                        mul_b = $signed({3'b0, cfg.coupling_weight});
                    end
                    4'd3:
                    begin
                        mul_a = 36'(ce_reg);
                        mul_b = $signed({3'b0, kl_reg[29:15]});
                    end
                    4'd4:
                    begin
                        mul_a = 36'(ce_reg);
                        mul_b = $signed({3'b0, kl_reg[14:0]});
                    end
                    4'd5:
                    begin
                        mul_a = gp_reg;
                        mul_b = $signed({3'b0, cfg.step_gain});
                    end
                    default:
                    begin
                        mul_a = gd_reg;
                        mul_b = $signed({3'b0, cfg.step_gain});
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign mac_term = fjik_pkg::TERM_NEG[cmd.idx] ? -prod : prod;
    assign acc_mac  = ((term == 2'd0) ? 64'sd0 : acc_reg) + 64'(mac_term);
    assign nsum     = ((term == 2'd0) ? 64'sd0 : acc_reg) + 64'(prod);
    assign gsum     = acc_reg + 64'(prod);

    assign z_init = cmd.fk ? $signed({2'b0, 16'({1'b0, pip_reg} + {1'b0, dip_reg}), 14'b0})
                           : $signed({{2{mcp_reg[15]}}, mcp_reg, 14'b0}) ;
    assign red    = reduce_angle(z_init);
    assign dx     = cy_reg >>> cmd.idx;
    assign dy     = cx_reg >>> cmd.idx;

    assign ey13    = 36'(qres_reg.y) <<< 13;
    assign r14     = (prod + 54'sd8192) >>> 14;
    assign r28     = (prod + 54'sd134217728) >>> 28;
    assign pip_sum = $signed({13'b0, pip_reg}) + 28'(r28);
    assign dip_sum = $signed({13'b0, dip_reg}) + 28'(r28);

    assign status.stop = stop_reg;
    assign pip_angle   = opip_reg;
    assign dip_angle   = odip_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            fjik_pkg::OP_LOAD:
            begin
                base_reg <= req.base;
                tip_reg  <= req.tip;
                mcp_reg  <= req.mcp_angle;
            end
            fjik_pkg::OP_ROT_INIT:
            begin
                cx_reg  <= fjik_pkg::CORDIC_X0;
                cy_reg  <= '0;
                cz_reg  <= $signed(red[31:0]);
                neg_reg <= red[32];
            end
            fjik_pkg::OP_ROT_STEP:
            begin
                if (!cz_reg[31])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - fjik_pkg::ATAN_TAB[cmd.idx];
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + fjik_pkg::ATAN_TAB[cmd.idx];
                end
            end
            fjik_pkg::OP_ROT_DONE:
            begin
                rc_reg <= rot_out(cx_reg, neg_reg);
                rs_reg <= rot_out(cy_reg, neg_reg);
            end
            fjik_pkg::OP_MAC:
            begin
                acc_reg <= acc_mac;
                if (term == 2'd3)
                begin
                    if (cmd.msel == fjik_pkg::MS_REL)
                        qrel_reg <= qset(qrel_reg, comp, qfix(acc_mac));
                    else
                        qres_reg <= qset(qres_reg, comp, qfix(acc_mac));
                end
            end
            fjik_pkg::OP_ERR_FIX:
            begin
                if (qres_reg.w < 16'sd0)
                begin
                    qres_reg.w <= neg_sat(qres_reg.w);
                    qres_reg.x <= neg_sat(qres_reg.x);
                    qres_reg.y <= neg_sat(qres_reg.y);
                    qres_reg.z <= neg_sat(qres_reg.z);
                end
            end
            fjik_pkg::OP_NORM:
            begin
                if (term == 2'd3)
                    stop_reg <= acc_reg < 64'(prod);
                else
                    acc_reg <= nsum;
            end
            fjik_pkg::OP_GRAD:
            begin
                case (cmd.idx)
                    4'd0: ce_reg <= $signed({3'b0, dip_reg, 14'b0}) - $signed(prod[31:0]);
                    4'd1: kl_reg <= prod[29:0];
                    4'd2: gd_reg <= ey13 - 36'(r14);
                    4'd3: acc_reg <= 64'(prod) <<< 15;
                    4'd4: gp_reg <= ey13 + 36'((gsum + 64'sd134217728) >>> 28);
                    default: ;
                endcase
            end
            fjik_pkg::OP_OUT:
            begin
                opip_reg <= pip_reg;
                odip_reg <= dip_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pip_reg <= '0;
            dip_reg <= '0;
        end
        else if (cmd.op == fjik_pkg::OP_GRAD)
        begin
            if (cmd.idx == 4'd5)
                pip_reg <= clamp_angle(pip_sum, cfg.pip_upper_limit);
            else if (cmd.idx == fjik_pkg::GRAD_LAST)
                dip_reg <= clamp_angle(dip_sum, cfg.dip_upper_limit);
        end
    end

endmodule

FILE: hw/rtl/finger_joint_ik_solver_top.sv
// Finger joint ik solver. Each request runs the base rotation and products, then n
// refinement steps (n at most iteration_limit); a step that ends on the error norm
// test skips the gradient update. The work is done by the 16-step cordic and the
// single shared multiplier, which takes the 16 terms of each quaternion product and
// the norm and gradient terms one per cycle. One request is worked on at a time; the
// next is accepted while a finished result waits. Configuration is to be written over
// apb while the block is idle; the block itself does not enforce this.
// top level: joins config, controller and datapath; depends on fjik_pkg and the
// fjik_req_if / fjik_rsp_if interfaces
module finger_joint_ik_solver_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    fjik_req_if.sink      in_ch,
    fjik_rsp_if.source    out_ch
);

    fjik_pkg::cfg_t       cfg;
    fjik_pkg::dp_cmd_t    cmd;
    fjik_pkg::dp_status_t status;
    fjik_pkg::req_t       req;

    assign req.base.w    = in_ch.base_w;
    assign req.base.x    = in_ch.base_x;
    assign req.base.y    = in_ch.base_y;
    assign req.base.z    = in_ch.base_z;
    assign req.mcp_angle = in_ch.mcp_angle;
    assign req.tip.w     = in_ch.tip_w;
    assign req.tip.x     = in_ch.tip_x;
    assign req.tip.y     = in_ch.tip_y;
    assign req.tip.z     = in_ch.tip_z;

    fjik_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fjik_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .iter_limit (cfg.iteration_limit),
        .status     (status),
        .cmd        (cmd)
    );

    fjik_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .req       (req),
        .status    (status),
        .pip_angle (out_ch.pip_angle),
        .dip_angle (out_ch.dip_angle)
    );

    // a request in work blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("accepted a request while one is in work");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == fjik_pkg::OP_OUT |-> !out_ch.valid || out_ch.ready)
        else $error("result register loaded while a result waits");

    // inputs are captured only on an accepted request
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == fjik_pkg::OP_LOAD |-> in_ch.valid && in_ch.ready)
        else $error("request captured without handshake");

endmodule
